### design/tof_height_filter_core_assert.svh
// Assertion macros shared by the tof height filter checkers.
// Bodies expect clk and rst_n to be visible where they are used.
`ifndef TOF_HEIGHT_FILTER_CORE_ASSERT_SVH
`define TOF_HEIGHT_FILTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TOF_HF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TOF_HF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tof_hf_pkg.sv
// Package for the tof height filter: constants, register indexes and the
// item type passed from the front end to the filter back end. No dependencies.
package tof_hf_pkg;

    localparam int DistW     = 16;
    localparam int StrW      = 16;
    localparam int StampW    = 32;
    localparam int IntervalW = 8;
    localparam int HeightW   = 24;
    localparam int VelW      = 25;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 16;

    localparam logic [7:0] HeaderByte = 8'h59;

    localparam logic [StrW-1:0]      StrengthLowReset  = 16'd500;
    localparam logic [StrW-1:0]      StrengthHighReset = 16'd60000;
    localparam logic [IntervalW-1:0] IntervalMinReset  = 8'd5;
    localparam logic [IntervalW-1:0] IntervalMaxReset  = 8'd50;

    // x / 10 == (x * Recip10) >> Recip10Shift for every x below 2**26
    localparam logic [23:0] Recip10      = 24'd13421773;
    localparam int          Recip10Shift = 27;

    localparam int QueueDepthDefault = 2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_STRENGTH_LOW  = 2'd0,
        CFG_STRENGTH_HIGH = 2'd1,
        CFG_INTERVAL_MIN  = 2'd2,
        CFG_INTERVAL_MAX  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                 header_ok;
        logic                 sample_taken;
        logic [DistW-1:0]     distance_cm;
        logic [IntervalW-1:0] interval_ms;
    } tof_hf_item_t;

endpackage

### design/tof_hf_front.sv
// Front end: takes input items, checks header and strength window, clamps
// the frame interval. Holds the configuration registers. Uses tof_hf_pkg.
module tof_hf_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [7:0]                           head_first,
    input  logic [7:0]                           head_second,
    input  logic [tof_hf_pkg::DistW-1:0]         distance_cm,
    input  logic [tof_hf_pkg::StrW-1:0]          strength,
    input  logic [tof_hf_pkg::StampW-1:0]        now_ms,
    input  logic                                 cfg_write_en,
    input  logic [tof_hf_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [tof_hf_pkg::CfgDataW-1:0]      cfg_data,
    input  logic                                 q_full,
    output logic                                 q_push,
    output tof_hf_pkg::tof_hf_item_t             q_item
);
    import tof_hf_pkg::*;

    logic [StrW-1:0]      strength_low_reg;
    logic [StrW-1:0]      strength_high_reg;
    logic [IntervalW-1:0] interval_min_reg;
    logic [IntervalW-1:0] interval_max_reg;
    logic [StampW-1:0]    last_stamp_reg;
    logic [StampW-1:0]    last_stamp_next;
    logic [IntervalW-1:0] interval_reg;
    logic [IntervalW-1:0] interval_next;

    logic                 accept;
    logic                 hdr_ok;
    logic                 str_ok;
    logic [StampW-1:0]    delta;
    logic [IntervalW-1:0] clamped;

    assign accept = push && !q_full;
    assign q_push = accept;
    assign hdr_ok = (head_first == HeaderByte) && (head_second == HeaderByte);
    assign str_ok = (strength > strength_low_reg) && (strength < strength_high_reg);
    assign delta  = now_ms - last_stamp_reg;

    always_comb
    begin
        if (delta < {{(StampW-IntervalW){1'b0}}, interval_min_reg})
        begin
            clamped = interval_min_reg;
        end
        else if (delta > {{(StampW-IntervalW){1'b0}}, interval_max_reg})
        begin
            clamped = interval_max_reg;
        end
        else
        begin
            clamped = delta[IntervalW-1:0];
        end
    end

    always_comb
    begin
        interval_next   = interval_reg;
        last_stamp_next = last_stamp_reg;
        if (accept && hdr_ok)
        begin
            interval_next   = clamped;
            last_stamp_next = now_ms;
        end
    end

    always_comb
    begin
        q_item.header_ok    = hdr_ok;
        q_item.sample_taken = hdr_ok && str_ok;
        q_item.distance_cm  = distance_cm;
        q_item.interval_ms  = hdr_ok ? clamped : interval_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_low_reg  <= StrengthLowReset;
            strength_high_reg <= StrengthHighReset;
            interval_min_reg  <= IntervalMinReset;
            interval_max_reg  <= IntervalMaxReset;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STRENGTH_LOW:  strength_low_reg  <= cfg_data;
                CFG_STRENGTH_HIGH: strength_high_reg <= cfg_data;
                CFG_INTERVAL_MIN:  interval_min_reg  <= cfg_data[IntervalW-1:0];
                CFG_INTERVAL_MAX:  interval_max_reg  <= cfg_data[IntervalW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            interval_reg   <= '0;
        end
        else
        begin
            last_stamp_reg <= last_stamp_next;
            interval_reg   <= interval_next;
        end
    end

endmodule

### design/tof_hf_queue.sv
// Short item queue between the front end and the filter back end.
// Uses tof_hf_pkg for the item type.
module tof_hf_queue #(
    parameter int DEPTH = tof_hf_pkg::QueueDepthDefault
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  tof_hf_pkg::tof_hf_item_t in_item,
    output logic                     full,
    input  logic                     pop,
    output logic                     empty,
    output tof_hf_pkg::tof_hf_item_t out_item
);
    import tof_hf_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    tof_hf_item_t    mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_wr;
    logic            do_rd;

    assign full     = (count_reg == CntW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_wr    = push && !full;
    assign do_rd    = pop && !empty;
    assign out_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/tof_hf_back.sv
// Back end: runs the height filter update on each queued item with a taken sample and holds the
// result in an output register until it is popped. Uses tof_hf_pkg.
module tof_hf_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    input  tof_hf_pkg::tof_hf_item_t               q_item,
    output logic                                   q_pop,
    input  logic                                   pop,
    output logic                                   empty,
    output logic                                   header_ok,
    output logic                                   sample_taken,
    output logic [tof_hf_pkg::HeightW-1:0]         height_q8,
    output logic signed [tof_hf_pkg::VelW-1:0]     velocity_q8,
    output logic [tof_hf_pkg::IntervalW-1:0]       interval_ms
);
    import tof_hf_pkg::*;

    localparam int ProdW = HeightW + 24;
    localparam int QuotW = ProdW - Recip10Shift;

    logic [HeightW-1:0]     height_reg;
    logic [HeightW-1:0]     height_next;
    logic signed [VelW-1:0] vel_reg;
    logic signed [VelW-1:0] vel_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [HeightW-1:0]     sample;
    logic signed [VelW-1:0] diff;
    logic                   neg;
    logic [HeightW-1:0]     mag;
    logic [ProdW-1:0]       prod;
    logic [QuotW-1:0]       quot;
    logic signed [VelW-1:0] quot_s;
    logic signed [VelW-1:0] step;
    logic signed [VelW-1:0] sum;

    assign q_pop = !q_empty && (!out_valid_reg || pop);
    assign empty = !out_valid_reg;

    // Divide by ten with truncation toward zero: work on the magnitude.
    assign sample = {q_item.distance_cm, 8'h00};
    assign diff   = $signed({1'b0, sample}) - $signed({1'b0, height_reg});
    assign neg    = diff[VelW-1];
    assign mag    = neg ? HeightW'(-diff) : diff[HeightW-1:0];
    assign prod   = {{(ProdW-HeightW){1'b0}}, mag} * {{(ProdW-24){1'b0}}, Recip10};
    assign quot   = prod[ProdW-1:Recip10Shift];
    assign quot_s = $signed({{(VelW-QuotW){1'b0}}, quot});
    assign step   = neg ? -quot_s : quot_s;
    assign sum    = $signed({1'b0, height_reg}) + step;

    always_comb
    begin
        height_next    = height_reg;
        vel_next       = vel_reg;
        out_valid_next = out_valid_reg;
        if (q_pop && q_item.sample_taken)
        begin
            height_next = sum[HeightW-1:0];
            vel_next    = step;
        end
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg    <= '0;
            vel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            height_reg    <= height_next;
            vel_reg       <= vel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: load on each item moved out of the queue.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            header_ok    <= q_item.header_ok;
            sample_taken <= q_item.sample_taken;
            height_q8    <= height_next;
            velocity_q8  <= vel_next;
            interval_ms  <= q_item.interval_ms;
        end
    end

endmodule

### design/tof_height_filter_core.sv
// An item accepted by the front end is written into a small queue, then into the result
// registers when the back end pops it. Throughput: one item per cycle while the result is
// empty or popped; the filter loop (subtract, multiply by 1/10, add) is in the back end.
// Reset: rst_n asynchronous, active low; config registers go to their defaults, height,
// velocity, interval and stamp to zero, and the queue empty.
module tof_height_filter_core #(
    parameter int QUEUE_DEPTH = tof_hf_pkg::QueueDepthDefault
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [7:0]                           head_first,
    input  logic [7:0]                           head_second,
    input  logic [tof_hf_pkg::DistW-1:0]         distance_cm,
    input  logic [tof_hf_pkg::StrW-1:0]          strength,
    input  logic [tof_hf_pkg::StampW-1:0]        now_ms,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 header_ok,
    output logic                                 sample_taken,
    output logic [tof_hf_pkg::HeightW-1:0]       height_q8,
    output logic signed [tof_hf_pkg::VelW-1:0]   velocity_q8,
    output logic [tof_hf_pkg::IntervalW-1:0]     interval_ms,
    input  logic                                 cfg_write_en,
    input  logic [tof_hf_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [tof_hf_pkg::CfgDataW-1:0]      cfg_data
);
    import tof_hf_pkg::*;

    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    tof_hf_item_t q_in;
    tof_hf_item_t q_out;

    assign full = q_full;

    tof_hf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .head_first   (head_first),
        .head_second  (head_second),
        .distance_cm  (distance_cm),
        .strength     (strength),
        .now_ms       (now_ms),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_in)
    );

    tof_hf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .in_item  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .out_item (q_out)
    );

    tof_hf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (q_out),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .header_ok    (header_ok),
        .sample_taken (sample_taken),
        .height_q8    (height_q8),
        .velocity_q8  (velocity_q8),
        .interval_ms  (interval_ms)
    );

endmodule

### design/tof_hf_checker.sv
// Port-level checks for tof_height_filter_core, bound to the top level.
// Uses tof_hf_pkg and the macros in tof_height_filter_core_assert.svh.
`include "tof_height_filter_core_assert.svh"

module tof_hf_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 push,
    input logic                                 full,
    input logic                                 empty,
    input logic                                 pop,
    input logic                                 header_ok,
    input logic                                 sample_taken,
    input logic [tof_hf_pkg::HeightW-1:0]       height_q8,
    input logic signed [tof_hf_pkg::VelW-1:0]   velocity_q8,
    input logic [tof_hf_pkg::IntervalW-1:0]     interval_ms
);
    import tof_hf_pkg::*;

    // Largest step the filter can make: one tenth of the largest scaled sample (distance_cm << 8).
    localparam logic signed [VelW-1:0] VelLimit = 25'sd1677696;

    `TOF_HF_ASSERT_NOW(a_take_needs_header, !empty && sample_taken, header_ok, "sample taken without good header")
    `TOF_HF_ASSERT_NOW(a_full_implies_result, full, !empty, "input queue full while no result waits")
    `TOF_HF_ASSERT_NOW(a_velocity_bound, !empty, (velocity_q8 <= VelLimit) && (velocity_q8 >= -VelLimit), "velocity beyond one filter step")
    `TOF_HF_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(height_q8) && $stable(velocity_q8) && $stable(interval_ms), "stalled result changed")

endmodule

bind tof_height_filter_core tof_hf_checker u_checker (.*);
